@@ rtl/tss_pkg.sv @@
// Shared types and constants for the trimmed sample statistics block.
// No dependencies.
package tss_pkg;
   localparam int SAMPLE_W = 24;
   localparam int REG_W    = 11;
   localparam int MED_W    = 25;
   localparam int VAR_W    = 48;
   localparam int STAT_W   = 2;
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OVF   = 2'd2;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

   // configuration register indexes
   localparam logic CSR_WARM_UP = 1'b0;
   localparam logic CSR_DISCARD = 1'b1;

   // datapath operations issued by the controller
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_LOAD    = 4'd1;
   localparam logic [3:0] OP_ZERO    = 4'd2;
   localparam logic [3:0] OP_SORT    = 4'd3;
   localparam logic [3:0] OP_SCAN    = 4'd4;
   localparam logic [3:0] OP_DIV1    = 4'd5;
   localparam logic [3:0] OP_SQ      = 4'd6;
   localparam logic [3:0] OP_DIV2    = 4'd7;
   localparam logic [3:0] OP_MED     = 4'd8;
   localparam logic [3:0] OP_FINISH  = 4'd9;

   typedef struct packed {
      logic [3:0] op;
      logic       first;  // first cycle of an operation
   } cmd_type;

   typedef struct packed {
      logic done;       // current operation finished
   } stat_type;
endpackage

@@ rtl/tss_datapath.sv @@
// Datapath: sample memory, warm-up zeroing, insertion sort, scan, square pass, divider and median read.
// Depends on tss_pkg.
module tss_datapath #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tss_pkg::cmd_type           cmd,
   output tss_pkg::stat_type          stat,
   input  logic [tss_pkg::SAMPLE_W-1:0] in_sample,
   input  logic [tss_pkg::REG_W-1:0]  warm_up,
   input  logic [tss_pkg::REG_W-1:0]  discard,
   output logic [tss_pkg::SAMPLE_W-1:0] min_out,
   output logic [tss_pkg::SAMPLE_W-1:0] max_out,
   output logic [tss_pkg::MED_W-1:0]  med_out,
   output logic [tss_pkg::VAR_W-1:0]  var_out,
   output logic [tss_pkg::STAT_W-1:0] status_out
);
   import tss_pkg::*;
   localparam int AW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int SW = SAMPLE_W + CW;        // sum width
   localparam int TW = 2 * SAMPLE_W + CW;    // sum of squares width
   localparam int QW = 2 * CW;               // r*r / cnt*b width

   logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
   logic [SAMPLE_W-1:0] rd_ff;

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   // sort / scan indexes
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [SAMPLE_W-1:0] v_ff, v_in;
   logic [2:0] ph_ff, ph_in;
   logic [SAMPLE_W-1:0] mn_ff, mn_in, mx_ff, mx_in;
   logic [SW-1:0] s_ff, s_in;
   logic [TW-1:0] t_ff, t_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   // divider
   logic [TW-1:0] dq_ff, dq_in, dr_ff, dr_in;
   logic [$clog2(TW+1)-1:0] dk_ff, dk_in;
   logic [SW-1:0] q_ff, q_in;
   logic [CW-1:0] r_ff, r_in;
   logic [SAMPLE_W-1:0] first_ff, first_in;
   logic [MED_W-1:0] med_ff, med_in;
   logic [VAR_W-1:0] var_ff, var_in;
   logic [STAT_W-1:0] st_ff, st_in;
   logic [SAMPLE_W-1:0] d_ff, d_in;
   logic [2*SAMPLE_W-1:0] dsq_ff, dsq_in;
   logic done_in;

   logic          we;
   logic [AW-1:0] wa, ra;
   logic [SAMPLE_W-1:0] wd;
   logic [CW:0]   lohi;
   logic          empty;
   logic [CW-1:0] hi, mid;
   logic [TW:0]   trial;
   logic [QW-1:0] lhs, rhs;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   assign lohi  = {1'b0, warm_up} + {1'b0, discard};
   assign empty = lohi >= {1'b0, count_ff};
   assign hi    = count_ff - CW'(discard);
   assign mid   = CW'(({1'b0, count_ff} + 1'b1) >> 1);
   assign trial = {dr_ff, dq_ff[TW-1]};
   // remainder is below the divisor, so its low CW bits hold it
   assign lhs   = QW'(cnt_ff) * QW'(dr_ff[CW-1:0]);
   assign rhs   = QW'(r_ff) * QW'(r_ff);

   always_comb begin
      count_in = count_ff; ovf_in = ovf_ff;
      i_in = i_ff; j_in = j_ff; v_in = v_ff; ph_in = ph_ff;
      mn_in = mn_ff; mx_in = mx_ff; s_in = s_ff; t_in = t_ff; cnt_in = cnt_ff;
      dq_in = dq_ff; dr_in = dr_ff; dk_in = dk_ff; q_in = q_ff; r_in = r_ff;
      first_in = first_ff; med_in = med_ff; var_in = var_ff; st_in = st_ff;
      d_in = d_ff; dsq_in = dsq_ff;
      done_in = 1'b0;
      we = 1'b0; wa = '0; wd = '0; ra = AW'(j_ff);
      case (cmd.op)
         OP_LOAD: begin
            if (count_ff < CW'(MAX_SAMPLES)) begin
               we = 1'b1; wa = AW'(count_ff); wd = in_sample;
               count_in = count_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end
         OP_ZERO: begin
            if (cmd.first) i_in = '0;
            else begin
               if ({1'b0, i_ff} < {1'b0, count_ff} && i_ff < CW'(warm_up)) begin
                  we = 1'b1; wa = AW'(i_ff); wd = '0;
                  i_in = i_ff + 1'b1;
               end else done_in = 1'b1;
            end
         end
         OP_SORT: begin
            // ph 0: read a[i]; 1: latch v; 2: read a[j-1], or insert v at 0; 3: compare, shift up or insert v
            if (cmd.first) begin
               i_in = CW'(1); ph_in = 3'd0;
            end else begin
               case (ph_ff)
                  3'd0: begin
                     if (i_ff >= count_ff) done_in = 1'b1;
                     else begin
                        ra = AW'(i_ff); j_in = i_ff; ph_in = 3'd1;
                     end
                  end
                  3'd1: begin
                     v_in = rd_ff; ph_in = 3'd2;
                  end
                  3'd2: begin
                     if (j_ff == '0) begin
                        we = 1'b1; wa = AW'(j_ff); wd = v_ff;
                        i_in = i_ff + 1'b1; ph_in = 3'd0;
                     end else begin
                        ra = AW'(j_ff - 1'b1); ph_in = 3'd3;
                     end
                  end
                  3'd3: begin
                     if (rd_ff > v_ff) begin
                        we = 1'b1; wa = AW'(j_ff); wd = rd_ff;
                        j_in = j_ff - 1'b1; ph_in = 3'd2;
                     end else begin
                        we = 1'b1; wa = AW'(j_ff); wd = v_ff;
                        i_in = i_ff + 1'b1; ph_in = 3'd0;
                     end
                  end
                  default: ph_in = 3'd0;
               endcase
            end
         end
         OP_SCAN: begin
            // j issues reads, cnt counts returned data
            if (cmd.first) begin
               mn_in = FULL_SCALE; mx_in = '0; s_in = '0; var_in = '0;
               st_in = STAT_OK; cnt_in = '0;
               j_in = CW'(warm_up); ph_in = 3'd0;
               if (empty) begin
                  st_in = STAT_EMPTY; done_in = 1'b1;
               end
            end else begin
               ra = AW'(j_ff);
               if (j_ff < hi) j_in = j_ff + 1'b1;
               ph_in = {2'b00, (j_ff < hi)};
               if (ph_ff[0]) begin
                  if (rd_ff < mn_ff) mn_in = rd_ff;
                  if (rd_ff > mx_ff) mx_in = rd_ff;
                  s_in = s_ff + SW'(rd_ff);
                  cnt_in = cnt_ff + 1'b1;
               end
               if (!ph_ff[0] && !(j_ff < hi)) done_in = 1'b1;
            end
         end
         OP_DIV1, OP_DIV2: begin
            // restoring division, one quotient bit per cycle
            if (cmd.first) begin
               dq_in = (cmd.op == OP_DIV1) ? TW'(s_ff) : t_ff;
               dr_in = '0; dk_in = '0;
            end else if (dk_ff == ($clog2(TW+1))'(TW)) begin
               done_in = 1'b1;
               if (cmd.op == OP_DIV1) begin
                  q_in = SW'(dq_ff); r_in = CW'(dr_ff);
               end else begin
                  var_in = VAR_W'((lhs >= rhs || dq_ff == '0) ? dq_ff : dq_ff - 1'b1);
               end
            end else begin
               if (trial >= {1'b0, TW'(cnt_ff)}) begin
                  dr_in = TW'(trial - {1'b0, TW'(cnt_ff)});
                  dq_in = {dq_ff[TW-2:0], 1'b1};
               end else begin
                  dr_in = TW'(trial);
                  dq_in = {dq_ff[TW-2:0], 1'b0};
               end
               dk_in = dk_ff + 1'b1;
            end
         end
         OP_SQ: begin
            // pipeline: read, difference, square, accumulate
            if (cmd.first) begin
               t_in = '0; j_in = CW'(warm_up); ph_in = 3'd0;
            end else begin
               ra = AW'(j_ff);
               if (j_ff < hi) j_in = j_ff + 1'b1;
               ph_in = {ph_ff[1:0], (j_ff < hi)};
               if (ph_ff[0])
                  d_in = (SW'(rd_ff) >= q_ff) ? SAMPLE_W'(SW'(rd_ff) - q_ff)
                                              : SAMPLE_W'(q_ff - SW'(rd_ff));
               if (ph_ff[1]) dsq_in = d_ff * d_ff;
               if (ph_ff[2]) t_in = t_ff + TW'(dsq_ff);
               if (ph_ff == 3'd0 && !(j_ff < hi)) done_in = 1'b1;
            end
         end
         OP_MED: begin
            if (cmd.first) begin
               ph_in = 3'd0; first_in = '0; med_in = '0;
            end else begin
               case (ph_ff)
                  3'd0: begin
                     ra = AW'(mid - 1'b1); ph_in = 3'd1;
                  end
                  3'd1: begin
                     ra = AW'(mid); ph_in = 3'd2;
                     if (mid >= CW'(1) && mid - 1'b1 < count_ff) first_in = rd_ff;
                  end
                  default: begin
                     med_in = MED_W'(first_ff) +
                              ((mid < count_ff) ? MED_W'(rd_ff) : '0);
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         OP_FINISH: begin
            if (ovf_ff) st_in = STAT_OVF;
            count_in = '0; ovf_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; ovf_ff <= 1'b0; ph_ff <= '0;
      end else begin
         count_ff <= count_in; ovf_ff <= ovf_in; ph_ff <= ph_in;
      end
      i_ff <= i_in; j_ff <= j_in; v_ff <= v_in;
      mn_ff <= mn_in; mx_ff <= mx_in; s_ff <= s_in; t_ff <= t_in; cnt_ff <= cnt_in;
      dq_ff <= dq_in; dr_ff <= dr_in; dk_ff <= dk_in; q_ff <= q_in; r_ff <= r_in;
      first_ff <= first_in; med_ff <= med_in; var_ff <= var_in; st_ff <= st_in;
      d_ff <= d_in; dsq_ff <= dsq_in;
   end

   assign stat.done  = done_in;
   assign min_out    = mn_ff;
   assign max_out    = mx_ff;
   assign med_out    = med_ff;
   assign var_out    = var_ff;
   assign status_out = st_ff;
endmodule

@@ rtl/tss_ctrl.sv @@
// Controller sequencing load, zero, sort, scan, divide, square, divide, median and finish steps.
// Depends on tss_pkg.
module tss_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              last,
   input  tss_pkg::stat_type stat,
   output tss_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              strobe
);
   import tss_pkg::*;
   localparam logic [3:0] S_IDLE = 4'd0, S_ZERO = 4'd1, S_SORT = 4'd2, S_SCAN = 4'd3,
                          S_DIV1 = 4'd4, S_SQ = 4'd5, S_DIV2 = 4'd6, S_MED = 4'd7,
                          S_FIN = 4'd8, S_OUT = 4'd9;
   logic [3:0] state_ff, state_in;
   logic       first_ff, first_in;
   logic       empty_skip;

   // scan flags an empty range in its first cycle; then skip to median
   assign empty_skip = stat.done && first_ff && state_ff == S_SCAN;

   always_comb begin
      state_in = state_ff; first_in = 1'b0;
      cmd.op = OP_NONE; cmd.first = first_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op = OP_LOAD;
               if (last) begin
                  state_in = S_ZERO; first_in = 1'b1;
               end
            end
         end
         S_ZERO: cmd.op = OP_ZERO;
         S_SORT: cmd.op = OP_SORT;
         S_SCAN: cmd.op = OP_SCAN;
         S_DIV1: cmd.op = OP_DIV1;
         S_SQ:   cmd.op = OP_SQ;
         S_DIV2: cmd.op = OP_DIV2;
         S_MED:  cmd.op = OP_MED;
         S_FIN:  cmd.op = OP_FINISH;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_FIN) state_in = S_OUT;
      else if (state_ff != S_IDLE && state_ff != S_OUT && stat.done) begin
         first_in = 1'b1;
         state_in = empty_skip ? S_MED : state_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; first_ff <= 1'b0;
      end else begin
         state_ff <= state_in; first_ff <= first_in;
      end
   end

   assign busy   = state_ff != S_IDLE;
   assign strobe = state_ff == S_OUT;
endmodule

@@ rtl/trimmed_sample_statistics.sv @@
// Trimmed sample statistics top level. Throughput: one sample item per cycle while
// loading; busy stays high from the last item of a run until its result is given.
// After the last item the run goes through a zero pass over the warm-up samples, an
// insertion sort on one memory port, the scan and square passes, two 59-bit serial
// divisions, a median read and a finish step, then the strobe cycle.
// Synchronous active-high reset clears control, counts and config; results can't stall.
module trimmed_sample_statistics #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [23:0] req_sample_value,
   input  logic        req_last_sample,
   output logic        rsp_valid,
   output logic [23:0] rsp_min_value,
   output logic [23:0] rsp_max_value,
   output logic [24:0] rsp_median_twice,
   output logic [47:0] rsp_variance,
   output logic [1:0]  rsp_status,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);
   import tss_pkg::*;
   logic [REG_W-1:0] warm_ff, discard_ff;
   cmd_type  cmd;
   stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff <= '0; discard_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_WARM_UP) warm_ff <= csr_data;
         if (csr_index == CSR_DISCARD) discard_ff <= csr_data;
      end
   end

   tss_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .last(req_last_sample),
      .stat(stat), .cmd(cmd), .busy(busy), .strobe(rsp_valid)
   );

   tss_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_sample(req_sample_value), .warm_up(warm_ff), .discard(discard_ff),
      .min_out(rsp_min_value), .max_out(rsp_max_value), .med_out(rsp_median_twice),
      .var_out(rsp_variance), .status_out(rsp_status)
   );
endmodule

@@ rtl/tss_checker.sv @@
// Port-level checker for trimmed_sample_statistics, bound to the top level.
// Depends on tss_pkg.
module tss_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_last_sample,
   input logic        rsp_valid,
   input logic [23:0] rsp_min_value,
   input logic [23:0] rsp_max_value,
   input logic [47:0] rsp_variance,
   input logic [1:0]  rsp_status
);
   import tss_pkg::*;
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_sample |=> busy) else $error("no busy after last");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("strobe longer than one cycle");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STAT_OVF) else $error("bad status");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_EMPTY |-> rsp_variance == '0 &&
      rsp_max_value == '0 && rsp_min_value == FULL_SCALE) else $error("empty result");
endmodule

bind trimmed_sample_statistics tss_checker u_tss_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_last_sample(req_last_sample), .rsp_valid(rsp_valid),
   .rsp_min_value(rsp_min_value), .rsp_max_value(rsp_max_value),
   .rsp_variance(rsp_variance), .rsp_status(rsp_status)
);
